// ===== rtl/irlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlp_pkg
// Shared types and constants of the ident request line parser: phase and
// status codes, parser state and result records, register indexes.
// ----------------------------------------------------------------------------
package irlp_pkg;

  localparam int CHAR_W  = 8;
  localparam int PORT_W  = 16;
  localparam int COUNT_W = 9;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_UNKNOWN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES      = 2'd1;

  localparam logic [COUNT_W-1:0] MAX_BYTES_RESET = 9'd256;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_SRV       = 3'd1,
    PH_PRECOMMA  = 3'd2,
    PH_POSTCOMMA = 3'd3,
    PH_CLI       = 3'd4,
    PH_PREEOL    = 3'd5
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PARSING = 3'd0,
    ST_DONE    = 3'd1,
    ST_BADPORT = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_TOOLONG = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef struct packed {
    phase_t              phase;
    logic [PORT_W-1:0]   srv;
    logic [PORT_W-1:0]   cli;
    logic [COUNT_W-1:0]  count;
    logic                finished;
  } parse_state_t;

  typedef struct packed {
    status_t             status;
    logic [PORT_W-1:0]   server_port;
    logic [PORT_W-1:0]   client_port;
  } result_t;

  typedef struct packed {
    logic                report_unknown;
    logic [COUNT_W-1:0]  max_bytes;
  } cfg_t;

endpackage

// ===== rtl/irlp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlp_if
// Valid/ready channels of the parser: request bytes, results and
// register writes.
// ----------------------------------------------------------------------------
interface irlp_in_if import irlp_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              start_req;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output start_req, output char_in, input ready);
  modport sink   (input valid, input start_req, input char_in, output ready);
endinterface

interface irlp_out_if import irlp_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PORT_W-1:0] server_port;
  logic [PORT_W-1:0] client_port;

  modport source (output valid, output status, output server_port,
                  output client_port, input ready);
  modport sink   (input valid, input status, input server_port,
                  input client_port, output ready);
endinterface

interface irlp_cfg_if import irlp_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== rtl/irlp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlp_step
// Per-byte parser update: byte count limit, phase transitions, decimal
// port accumulation and the status of one byte.
// ----------------------------------------------------------------------------
module irlp_step import irlp_pkg::*; (
  input  parse_state_t      cur,
  input  logic              start_req,
  input  logic [CHAR_W-1:0] char_in,
  input  cfg_t              cfg,
  output parse_state_t      nxt,
  output result_t           res
);

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam int MAC_W = PORT_W + 4;

  parse_state_t       eff;
  logic               blank, digit, eol, comma, zero;
  logic [PORT_W-1:0]  dval;
  logic [MAC_W-1:0]   srv_mac, cli_mac;
  logic               srv_ovf, cli_ovf;
  logic [COUNT_W-1:0] count_inc;
  logic               bad, at_eol;
  phase_t             ph_new;
  status_t            fail_status;

  assign blank = (char_in == CH_SPACE) || (char_in == CH_TAB);
  assign eol   = (char_in == CH_CR) || (char_in == CH_LF);
  assign comma = (char_in == CH_COMMA);
  assign zero  = (char_in == CH_ZERO);
  assign digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign dval  = {{(PORT_W-4){1'b0}}, char_in[3:0]};

  // acc * 10 + digit as shifts and adds
  assign srv_mac = ({4'b0, eff.srv} << 3) + ({4'b0, eff.srv} << 1) + {4'b0, dval};
  assign cli_mac = ({4'b0, eff.cli} << 3) + ({4'b0, eff.cli} << 1) + {4'b0, dval};
  assign srv_ovf = |srv_mac[MAC_W-1:PORT_W];
  assign cli_ovf = |cli_mac[MAC_W-1:PORT_W];

  assign fail_status = cfg.report_unknown ? ST_UNKNOWN : ST_BADPORT;

  always_comb begin
    if (start_req) begin
      eff.phase    = PH_START;
      eff.srv      = '0;
      eff.cli      = '0;
      eff.count    = '0;
      eff.finished = 1'b0;
    end else begin
      eff = cur;
    end
  end

  assign count_inc = eff.count + {{(COUNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    nxt    = eff;
    bad    = 1'b0;
    at_eol = 1'b0;
    ph_new = eff.phase;
    case (eff.phase)
      PH_START, PH_POSTCOMMA: begin
        if (!blank) begin
          if (!digit || zero) begin
            bad = 1'b1;
          end else if (eff.phase == PH_START) begin
            nxt.srv = dval;
            ph_new  = PH_SRV;
          end else begin
            nxt.cli = dval;
            ph_new  = PH_CLI;
          end
        end
      end
      PH_SRV: begin
        if (blank) begin
          ph_new = PH_PRECOMMA;
        end else if (comma) begin
          ph_new = PH_POSTCOMMA;
        end else if (!digit || srv_ovf) begin
          bad = 1'b1;
        end else begin
          nxt.srv = srv_mac[PORT_W-1:0];
        end
      end
      PH_PRECOMMA: begin
        if (comma) begin
          ph_new = PH_POSTCOMMA;
        end else if (!blank) begin
          bad = 1'b1;
        end
      end
      PH_CLI: begin
        if (blank) begin
          ph_new = PH_PREEOL;
        end else if (eol) begin
          at_eol = 1'b1;
        end else if (!digit || cli_ovf) begin
          bad = 1'b1;
        end else begin
          nxt.cli = cli_mac[PORT_W-1:0];
        end
      end
      PH_PREEOL: begin
        if (eol) begin
          at_eol = 1'b1;
        end else if (!blank) begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    res.status      = ST_PARSING;
    res.server_port = '0;
    res.client_port = '0;

    if (eff.finished) begin
      nxt        = eff;
      res.status = ST_IGNORED;
    end else if (count_inc >= cfg.max_bytes) begin
      nxt          = eff;
      nxt.count    = count_inc;
      nxt.finished = 1'b1;
      res.status   = ST_TOOLONG;
    end else begin
      nxt.count = count_inc;
      if (bad) begin
        nxt.finished = 1'b1;
        res.status   = fail_status;
      end else if (at_eol) begin
        nxt.finished = 1'b1;
        if ((eff.srv == '0) || (eff.cli == '0)) begin
          res.status = fail_status;
        end else begin
          res.status      = ST_DONE;
          res.server_port = eff.srv;
          res.client_port = eff.cli;
        end
      end else begin
        nxt.phase = ph_new;
      end
    end
  end

endmodule

// ===== rtl/ident_request_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ident_request_line_parser
// Parses "server port , client port" request lines one byte per transaction
// and returns a status, plus both ports on completion, for every byte.
// ----------------------------------------------------------------------------
// pipeline: the input register loads at the accepting edge, and the parser update
//   goes into the result register when advance is high (no result held, or
//   out_ch ready)
// throughput: one byte per cycle while no held result stalls on out_ch.ready
// reset: synchronous active-low rst_n clears parser state, byte count and
//   pipeline valids; registers return to report invalid port, limit 256
module ident_request_line_parser import irlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  irlp_in_if.sink     in_ch,
  irlp_out_if.source  out_ch,
  irlp_cfg_if.sink    cfg_ch
);

  logic              s1_valid_r;
  logic              s1_start_r;
  logic [CHAR_W-1:0] s1_char_r;
  parse_state_t      state_r, state_nxt;
  logic              out_valid_r;
  result_t           out_r, res_nxt;
  cfg_t              cfg_r;
  logic              advance;
  logic              in_ready;

  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || advance;

  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.server_port = out_r.server_port;
  assign out_ch.client_port = out_r.client_port;

  irlp_step u_step (
    .cur       (state_r),
    .start_req (s1_start_r),
    .char_in   (s1_char_r),
    .cfg       (cfg_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_start_r <= in_ch.start_req;
      s1_char_r  <= in_ch.char_in;
    end
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase    <= PH_START;
      state_r.srv      <= '0;
      state_r.cli      <= '0;
      state_r.count    <= '0;
      state_r.finished <= 1'b0;
      out_valid_r      <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_r <= res_nxt;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.report_unknown <= 1'b0;
      cfg_r.max_bytes      <= MAX_BYTES_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        CFG_REPORT_UNKNOWN: cfg_r.report_unknown <= cfg_ch.data[0];
        CFG_MAX_BYTES:      cfg_r.max_bytes      <= cfg_ch.data[COUNT_W-1:0];
        default:            ;
      endcase
    end
  end

  a_ignored_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.finished && s1_valid_r && !s1_start_r && advance)
      |=> (out_valid_r && out_r.status == ST_IGNORED))
    else $error("byte after end of request not reported as ignored");

  a_done_ports: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_DONE)
      |-> (out_r.server_port != '0 && out_r.client_port != '0))
    else $error("completed request with a zero port");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a held result");

endmodule

// ===== dv/ident_request_line_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ident_request_line_parser_test
// Self-checking bench for the ident request line parser. A queue of request
// bytes feeds a valid/ready driver, and every accepted byte is run through an
// in-bench parser that predicts status and ports. A monitor checks every
// result transaction against the oldest prediction. Directed lines cover
// port extremes, overflow, leading zero, limit abort and ignored bytes. The
// random phases are mostly well-formed lines with random ports and blanks,
// plus broken lines and noise, under several register settings and
// idle/stall patterns.
// ----------------------------------------------------------------------------
module ident_request_line_parser_test;
  import irlp_pkg::*;

  localparam int RUN_LIMIT_NS    = 4_000_000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int NUM_PHASES      = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic       start;
    logic [7:0] ch;
  } req_byte_t;

  logic clk;
  logic rst_n;

  irlp_in_if  in_ch ();
  irlp_out_if out_ch ();
  irlp_cfg_if cfg_ch ();

  ident_request_line_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  req_byte_t tx_bytes[$];
  req_byte_t line_buf[$];
  result_t   status_due[$];

  int err_count     = 0;
  int queued_items  = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // parser copy and register copy
  logic               rpt_unknown;
  logic [COUNT_W-1:0] byte_limit;
  phase_t             parse_ph;
  logic [PORT_W-1:0]  srv_acc;
  logic [PORT_W-1:0]  cli_acc;
  logic [COUNT_W-1:0] byte_cnt;
  logic               req_done;

  int phase_rpt   [NUM_PHASES] = '{0, 1, 0, 1, 0, 1, 0};
  int phase_limit [NUM_PHASES] = '{256, 511, 14, 1, 511, 24, 256};

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == CH_SP || ch == CH_TAB;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  function automatic logic is_eol(input logic [7:0] ch);
    return ch == CH_CR || ch == CH_LF;
  endfunction

  function automatic void clear_parser();
    parse_ph = PH_START;
    srv_acc  = '0;
    cli_acc  = '0;
    byte_cnt = '0;
    req_done = 1'b0;
  endfunction

  function automatic result_t parse_byte(input logic start, input logic [7:0] ch);
    result_t r;
    logic    bad;
    logic    eol;
    int      acc;
    r.status      = ST_PARSING;
    r.server_port = '0;
    r.client_port = '0;
    bad = 1'b0;
    eol = 1'b0;
    if (start) clear_parser();
    if (req_done) begin
      r.status = ST_IGNORED;
      return r;
    end
    byte_cnt = byte_cnt + COUNT_W'(1);
    if (byte_cnt >= byte_limit) begin
      req_done = 1'b1;
      r.status = ST_TOOLONG;
      return r;
    end
    case (parse_ph)
      PH_START, PH_POSTCOMMA: begin
        if (!is_blank(ch)) begin
          if (!is_digit(ch) || ch == CH_ZERO) begin
            bad = 1'b1;
          end else if (parse_ph == PH_START) begin
            srv_acc  = PORT_W'(ch - CH_ZERO);
            parse_ph = PH_SRV;
          end else begin
            cli_acc  = PORT_W'(ch - CH_ZERO);
            parse_ph = PH_CLI;
          end
        end
      end
      PH_SRV: begin
        if (is_blank(ch)) parse_ph = PH_PRECOMMA;
        else if (ch == CH_COMMA) parse_ph = PH_POSTCOMMA;
        else if (!is_digit(ch)) bad = 1'b1;
        else begin
          acc = int'(srv_acc) * 10 + int'(ch) - int'(CH_ZERO);
          if (acc > 65535) bad = 1'b1;
          else srv_acc = PORT_W'(acc);
        end
      end
      PH_PRECOMMA: begin
        if (ch == CH_COMMA) parse_ph = PH_POSTCOMMA;
        else if (!is_blank(ch)) bad = 1'b1;
      end
      PH_CLI: begin
        if (is_blank(ch)) parse_ph = PH_PREEOL;
        else if (is_eol(ch)) eol = 1'b1;
        else if (!is_digit(ch)) bad = 1'b1;
        else begin
          acc = int'(cli_acc) * 10 + int'(ch) - int'(CH_ZERO);
          if (acc > 65535) bad = 1'b1;
          else cli_acc = PORT_W'(acc);
        end
      end
      PH_PREEOL: begin
        if (is_eol(ch)) eol = 1'b1;
        else if (!is_blank(ch)) bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad || (eol && (srv_acc < 1 || cli_acc < 1))) begin
      req_done = 1'b1;
      r.status = rpt_unknown ? ST_UNKNOWN : ST_BADPORT;
    end else if (eol) begin
      req_done      = 1'b1;
      r.status      = ST_DONE;
      r.server_port = srv_acc;
      r.client_port = cli_acc;
    end
    return r;
  endfunction

  // clock and known input levels
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.start_req = 1'b0;
    in_ch.char_in   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx   = '0;
    cfg_ch.data  = '0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    req_byte_t nb;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        status_due.push_back(parse_byte(in_ch.start_req, in_ch.char_in));
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nb = tx_bytes.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.start_req <= nb.start;
          in_ch.char_in   <= nb.ch;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_due.size() == 0) begin
        $error("unexpected result transaction: status %0d", out_ch.status);
        err_count++;
      end else begin
        want = status_due.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_ch.status);
          err_count++;
        end
        if (out_ch.server_port !== want.server_port) begin
          $error("server_port expected %0d actual %0d", want.server_port,
                 out_ch.server_port);
          err_count++;
        end
        if (out_ch.client_port !== want.client_port) begin
          $error("client_port expected %0d actual %0d", want.client_port,
                 out_ch.client_port);
          err_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_REPORT_UNKNOWN) rpt_unknown = val[0];
    else if (idx == CFG_MAX_BYTES) byte_limit = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tx_bytes.size() != 0 || in_ch.valid || status_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_byte(input logic [7:0] ch);
    line_buf.push_back('{start: 1'b0, ch: ch});
  endtask

  task automatic add_blanks(input int n);
    for (int i = 0; i < n; i++) add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endtask

  task automatic add_number(input int val, input logic lead_zero);
    string s;
    s = $sformatf("%0d", val);
    if (lead_zero) add_byte(CH_ZERO);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic commit_line(input logic with_start);
    if (line_buf.size() != 0 && with_start) line_buf[0].start = 1'b1;
    foreach (line_buf[i]) tx_bytes.push_back(line_buf[i]);
    queued_items += line_buf.size();
    line_buf.delete();
  endtask

  function automatic int pick_port();
    case ($urandom_range(0, 4))
      0: return $urandom_range(1, 9);
      1: return $urandom_range(10, 999);
      2: return $urandom_range(1000, 65535);
      3: return 65535;
      default: return $urandom_range(65500, 65535);
    endcase
  endfunction

  task automatic build_line(input int lead, input int srv, input int cli, input int zero_at);
    add_blanks(lead);
    add_number(srv, zero_at == 1);
    add_blanks($urandom_range(0, 2));
    add_byte(CH_COMMA);
    add_blanks($urandom_range(0, 2));
    add_number(cli, zero_at == 2);
    add_blanks($urandom_range(0, 2));
    add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task automatic gen_request();
    int kind;
    int lead;
    int srv;
    int cli;
    int zero_at;
    int pos;
    kind    = $urandom_range(0, 99);
    lead    = $urandom_range(0, 3);
    srv     = pick_port();
    cli     = pick_port();
    zero_at = 0;
    if (kind >= 95 && kind < 97) lead = $urandom_range(200, 520);
    if (kind >= 65 && kind < 75) begin
      if ($urandom_range(0, 1)) srv = $urandom_range(65536, 99999);
      else cli = $urandom_range(65536, 99999);
    end
    if (kind >= 75 && kind < 80) zero_at = $urandom_range(1, 2);
    if (kind >= 90 && kind < 95) begin
      // noise
      repeat ($urandom_range(1, 8)) begin
        add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                      : 8'(CH_ZERO + $urandom_range(0, 9)));
        line_buf[line_buf.size()-1].start = ($urandom_range(0, 3) == 0);
      end
      commit_line(1'b0);
    end else begin
      build_line(lead, srv, cli, zero_at);
      if (kind >= 80 && kind < 90) begin
        pos = $urandom_range(0, line_buf.size() - 1);
        line_buf[pos].ch = 8'($urandom_range(0, 255));
      end
      commit_line(kind < 97);
    end
    if (kind < 65)
      repeat ($urandom_range(0, 2))
        tx_bytes.push_back('{start: 1'b0, ch: 8'($urandom_range(0, 255))});
  endtask

  initial begin
    rpt_unknown = 1'b0;
    byte_limit  = MAX_BYTES_RESET;
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, overflow, leading zero, ignored bytes
    write_reg(CFG_REPORT_UNKNOWN, 9'd0);
    write_reg(CFG_MAX_BYTES, 9'd256);
    @(negedge clk);
    add_byte(CH_TAB);
    add_number(1, 1'b0);
    add_byte(CH_COMMA);
    add_number(65535, 1'b0);
    add_byte(CH_CR);
    commit_line(1'b1);
    add_number(65536, 1'b0);
    commit_line(1'b1);
    add_byte(8'hFF);
    commit_line(1'b0);
    add_byte(CH_ZERO);
    commit_line(1'b1);
    wait_idle();

    // zero limit, unknown error mode, writes to unused indexes
    write_reg(CFG_REPORT_UNKNOWN, 9'h1FF);
    write_reg(CFG_MAX_BYTES, 9'd0);
    write_reg(CFG_UNUSED_A, 9'h1FF);
    write_reg(CFG_UNUSED_B, 9'h000);
    @(negedge clk);
    add_byte(8'h80);
    commit_line(1'b1);
    add_byte(8'h7F);
    commit_line(1'b0);
    wait_idle();

    write_reg(CFG_MAX_BYTES, 9'd511);
    @(negedge clk);
    add_number(9, 1'b0);
    add_byte(CH_SP);
    add_byte(CH_COMMA);
    add_byte(CH_SP);
    add_number(8, 1'b0);
    add_byte(CH_SP);
    add_byte(CH_LF);
    commit_line(1'b1);
    wait_idle();

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_REPORT_UNKNOWN, {8'($urandom_range(0, 255)), 1'(phase_rpt[p])});
      write_reg(CFG_MAX_BYTES, 9'(phase_limit[p]));
      write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                9'($urandom_range(0, 511)));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      @(negedge clk);
      queued_items = 0;
      while (queued_items < ITEMS_PER_PHASE / 2) gen_request();
      // sender holds off until all results are back
      if (p % 2 == 1) wait_idle();
      while (queued_items < ITEMS_PER_PHASE) gen_request();
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/irlp_pkg.sv
rtl/irlp_if.sv
rtl/irlp_step.sv
rtl/ident_request_line_parser.sv
dv/ident_request_line_parser_test.sv
